### rtl/rpmre_pkg.sv
// package for the rounded polynomial mixed-radix encoder
// holds widths, the transaction record, the back-end state type and the level schedule
// no dependencies
`timescale 1ns / 1ps

package rpmre_pkg;

  localparam int COEFF_COUNT = 653;
  localparam int ENC_BYTES   = 865;
  localparam int COEF_W      = 13;
  localparam int VAL_W       = 14;
  localparam int ADDR_W      = 10;
  localparam int IDX_W       = 10;
  localparam int SEG_W       = 4;
  localparam int CNT_W       = 9;
  localparam int ACC_W       = 28;
  localparam int PEND_W      = 24;

  localparam logic [COEF_W-1:0] Q_MAX    = 13'd4620;
  localparam logic [COEF_W-1:0] HALF_HI  = 13'd2311;
  localparam logic [COEF_W-1:0] HALF_LO  = 13'd2310;
  // ceil(2^17 / 3), exact floor division by three over the coefficient range
  localparam logic [16:0]       RECIP3   = 17'd43691;
  localparam logic [SEG_W-1:0]  LAST_SEG = 4'd15;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // one transaction between front and back
  typedef struct packed {
    logic              is_tick;
    logic [VAL_W-1:0]  value;
    logic [ADDR_W-1:0] index;
  } cmd_t;

  // one step of the encoding schedule: operand and destination bases,
  // number of operations, radix and bytes emitted per operation
  typedef struct packed {
    logic [ADDR_W-1:0] a0;
    logic [ADDR_W-1:0] b0;
    logic [ADDR_W-1:0] d0;
    logic [CNT_W-1:0]  count;
    logic [VAL_W-1:0]  radix;
    logic [1:0]        nb;
  } seg_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_MUL,
    B_ADD
  } bstate_t;

  // level schedule; copies use radix zero and emit no byte
  function automatic seg_t seg_info(input logic [SEG_W-1:0] s);
    seg_t r;
    case (s)
      4'd0:    r = '{10'd0,   10'd1,   10'd0,   9'd326, 14'd1541,  2'd1};
      4'd1:    r = '{10'd652, 10'd652, 10'd326, 9'd1,   14'd0,     2'd0};
      4'd2:    r = '{10'd0,   10'd1,   10'd0,   9'd163, 14'd9277,  2'd2};
      4'd3:    r = '{10'd326, 10'd326, 10'd163, 9'd1,   14'd0,     2'd0};
      4'd4:    r = '{10'd0,   10'd1,   10'd0,   9'd82,  14'd1314,  2'd1};
      4'd5:    r = '{10'd0,   10'd1,   10'd0,   9'd41,  14'd6745,  2'd2};
      4'd6:    r = '{10'd0,   10'd1,   10'd0,   9'd20,  14'd695,   2'd1};
      4'd7:    r = '{10'd40,  10'd40,  10'd20,  9'd1,   14'd0,     2'd0};
      4'd8:    r = '{10'd0,   10'd1,   10'd0,   9'd10,  14'd1887,  2'd1};
      4'd9:    r = '{10'd20,  10'd20,  10'd10,  9'd1,   14'd0,     2'd0};
      4'd10:   r = '{10'd0,   10'd1,   10'd0,   9'd5,   14'd13910, 2'd2};
      4'd11:   r = '{10'd10,  10'd10,  10'd5,   9'd1,   14'd0,     2'd0};
      4'd12:   r = '{10'd0,   10'd1,   10'd0,   9'd2,   14'd2953,  2'd2};
      4'd13:   r = '{10'd4,   10'd5,   10'd2,   9'd1,   14'd2953,  2'd1};
      4'd14:   r = '{10'd0,   10'd1,   10'd0,   9'd1,   14'd134,   2'd1};
      4'd15:   r = '{10'd0,   10'd2,   10'd0,   9'd1,   14'd71,    2'd3};
      default: r = '{10'd0,   10'd1,   10'd0,   9'd1,   14'd0,     2'd0};
    endcase
    return r;
  endfunction

endpackage

### rtl/rpmre_front.sv
// front end: accepts input transactions, filters them and converts coefficients
// depends on rpmre_pkg
`timescale 1ns / 1ps

module rpmre_front #(
  parameter int COEFF_COUNT = rpmre_pkg::COEFF_COUNT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  input  logic                         in_cmd,
  input  logic [rpmre_pkg::COEF_W-1:0] in_coef,
  input  logic                         q_full,
  output logic                         q_push,
  output rpmre_pkg::cmd_t              q_data
);

  logic [rpmre_pkg::IDX_W-1:0]  load_count_r, load_count_nxt;
  logic [rpmre_pkg::IDX_W-1:0]  tick_count_r, tick_count_nxt;
  logic                         accept;
  logic                         loaded;
  logic [rpmre_pkg::COEF_W-1:0] c_sat;
  logic [rpmre_pkg::COEF_W-1:0] v;
  logic [29:0]                  prod;

  assign accept = in_push && !q_full;
  assign loaded = (load_count_r == rpmre_pkg::IDX_W'(COEFF_COUNT));

  // saturate, center, divide by three
  always_comb begin
    c_sat = (in_coef > rpmre_pkg::Q_MAX) ? rpmre_pkg::Q_MAX : in_coef;
    v     = (c_sat >= rpmre_pkg::HALF_HI) ? (c_sat - rpmre_pkg::HALF_HI)
                                          : (c_sat + rpmre_pkg::HALF_LO);
    prod  = 30'(v) * 30'(rpmre_pkg::RECIP3);
  end

  // classify and forward
  always_comb begin
    q_push         = 1'b0;
    load_count_nxt = load_count_r;
    tick_count_nxt = tick_count_r;
    q_data.is_tick = in_cmd;
    q_data.value   = {1'b0, prod[29:17]};
    q_data.index   = load_count_r;
    if (accept) begin
      if (in_cmd == rpmre_pkg::CMD_LOAD) begin
        if (!loaded) begin
          q_push         = 1'b1;
          load_count_nxt = load_count_r + 1'b1;
        end
      end else if (loaded && tick_count_r != rpmre_pkg::IDX_W'(rpmre_pkg::ENC_BYTES)) begin
        q_push         = 1'b1;
        tick_count_nxt = tick_count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_count_r <= '0;
      tick_count_r <= '0;
    end else begin
      load_count_r <= load_count_nxt;
      tick_count_r <= tick_count_nxt;
    end
  end

endmodule

### rtl/rpmre_queue.sv
// two-entry queue between front and back
// depends on rpmre_pkg
`timescale 1ns / 1ps

module rpmre_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  rpmre_pkg::cmd_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output rpmre_pkg::cmd_t head
);

  rpmre_pkg::cmd_t ent0_r, ent0_nxt, ent1_r, ent1_nxt;
  logic [1:0]      cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign head  = ent0_r;

  // shift register storage, head in entry zero
  always_comb begin
    ent0_nxt = ent0_r;
    ent1_nxt = ent1_r;
    cnt_nxt  = cnt_r;
    if (pop && valid) begin
      ent0_nxt = ent1_r;
      cnt_nxt  = cnt_nxt - 1'b1;
    end
    if (push && !full) begin
      if (cnt_nxt == 2'd0) begin
        ent0_nxt = push_data;
      end else begin
        ent1_nxt = push_data;
      end
      cnt_nxt = cnt_nxt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    ent0_r <= ent0_nxt;
    ent1_r <= ent1_nxt;
  end

endmodule

### rtl/rpmre_back.sv
// back end: coefficient store, level sequencer, multiply-add and result register
// depends on rpmre_pkg
`timescale 1ns / 1ps

module rpmre_back #(
  parameter int COEFF_COUNT = rpmre_pkg::COEFF_COUNT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  rpmre_pkg::cmd_t             q_head,
  output logic                        q_pop,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [7:0]                  out_out_byte,
  output logic [rpmre_pkg::IDX_W-1:0] out_byte_index,
  output logic                        out_last
);

  logic [rpmre_pkg::VAL_W-1:0] mem [COEFF_COUNT];

  rpmre_pkg::bstate_t          state_r, state_nxt;
  logic [rpmre_pkg::SEG_W-1:0] seg_r, seg_nxt;
  logic [rpmre_pkg::CNT_W-1:0] k_r, k_nxt;
  logic [rpmre_pkg::PEND_W-1:0] pend_r, pend_nxt;
  logic [1:0]                  pend_cnt_r, pend_cnt_nxt;
  logic [rpmre_pkg::VAL_W-1:0] rda_r, rdb_r;
  logic [rpmre_pkg::ACC_W-1:0] prod_r;
  logic [rpmre_pkg::IDX_W-1:0] emit_count_r;
  logic                        out_valid_r;
  logic [7:0]                  out_byte_r;
  logic [rpmre_pkg::IDX_W-1:0] out_index_r;
  logic                        out_last_r;

  rpmre_pkg::seg_t             seg;
  logic [rpmre_pkg::ADDR_W-1:0] addr_a, addr_b, addr_d;
  logic [rpmre_pkg::ACC_W-1:0] acc;
  logic [rpmre_pkg::VAL_W-1:0] carry;
  logic                        out_free;
  logic                        emit;
  logic                        do_load;
  logic                        do_op;
  logic                        mem_we;
  logic [rpmre_pkg::ADDR_W-1:0] mem_waddr;
  logic [rpmre_pkg::VAL_W-1:0] mem_wdata;

  assign out_free = !out_valid_r || out_pop;

  // operand addresses from the schedule, the multiply-add sum and its carried part
  always_comb begin
    seg    = rpmre_pkg::seg_info(seg_r);
    addr_a = seg.a0 + {k_r, 1'b0};
    addr_b = seg.b0 + {k_r, 1'b0};
    addr_d = seg.d0 + rpmre_pkg::ADDR_W'(k_r);
    acc    = rpmre_pkg::ACC_W'(rda_r) + prod_r;
    case (seg.nb)
      2'd0:    carry = acc[13:0];
      2'd1:    carry = acc[21:8];
      2'd2:    carry = {2'b0, acc[27:16]};
      default: carry = {10'b0, acc[27:24]};
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rpmre_pkg::B_IDLE: begin
        if (q_valid && q_head.is_tick && pend_cnt_r == 2'd0) begin
          state_nxt = rpmre_pkg::B_READ;
        end
      end
      rpmre_pkg::B_READ: state_nxt = rpmre_pkg::B_MUL;
      rpmre_pkg::B_MUL:  state_nxt = rpmre_pkg::B_ADD;
      rpmre_pkg::B_ADD:  state_nxt = rpmre_pkg::B_IDLE;
      default:           state_nxt = rpmre_pkg::B_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    do_load = 1'b0;
    emit    = 1'b0;
    do_op   = 1'b0;
    case (state_r)
      rpmre_pkg::B_IDLE: begin
        if (q_valid && !q_head.is_tick) begin
          do_load = 1'b1;
        end else if (q_valid && pend_cnt_r != 2'd0 && out_free) begin
          emit = 1'b1;
        end
      end
      rpmre_pkg::B_ADD: do_op = 1'b1;
      default: begin
        do_load = 1'b0;
      end
    endcase
    q_pop     = do_load || emit;
    mem_we    = do_load || do_op;
    mem_waddr = do_load ? q_head.index : addr_d;
    mem_wdata = do_load ? q_head.value : carry;
  end

  // pending bytes and schedule position
  always_comb begin
    pend_nxt     = pend_r;
    pend_cnt_nxt = pend_cnt_r;
    seg_nxt      = seg_r;
    k_nxt        = k_r;
    if (emit) begin
      pend_nxt     = {8'b0, pend_r[rpmre_pkg::PEND_W-1:8]};
      pend_cnt_nxt = pend_cnt_r - 1'b1;
    end
    if (do_op) begin
      pend_nxt     = acc[rpmre_pkg::PEND_W-1:0];
      pend_cnt_nxt = seg.nb;
      if (k_r == seg.count - 1'b1) begin
        k_nxt = '0;
        if (seg_r != rpmre_pkg::LAST_SEG) begin
          seg_nxt = seg_r + 1'b1;
        end
      end else begin
        k_nxt = k_r + 1'b1;
      end
    end
  end

  // store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (state_r == rpmre_pkg::B_READ) begin
      rda_r <= mem[addr_a];
      rdb_r <= mem[addr_b];
    end
  end

  // multiply stage
  always_ff @(posedge clk) begin
    if (state_r == rpmre_pkg::B_MUL) begin
      prod_r <= rpmre_pkg::ACC_W'(rdb_r) * rpmre_pkg::ACC_W'(seg.radix);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= rpmre_pkg::B_IDLE;
      seg_r        <= '0;
      k_r          <= '0;
      pend_cnt_r   <= '0;
      emit_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      seg_r      <= seg_nxt;
      k_r        <= k_nxt;
      pend_cnt_r <= pend_cnt_nxt;
      if (emit) begin
        emit_count_r <= emit_count_r + 1'b1;
        out_valid_r  <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    if (emit) begin
      out_byte_r  <= pend_r[7:0];
      out_index_r <= emit_count_r;
      out_last_r  <= (emit_count_r == rpmre_pkg::IDX_W'(rpmre_pkg::ENC_BYTES - 1));
    end
  end

  assign out_empty      = !out_valid_r;
  assign out_out_byte   = out_byte_r;
  assign out_byte_index = out_index_r;
  assign out_last       = out_last_r;

endmodule

### rtl/rounded_poly_mixed_radix_encoder_top.sv
// top level of the rounded polynomial mixed-radix encoder
// depends on rpmre_pkg, rpmre_front, rpmre_queue, rpmre_back
`timescale 1ns / 1ps

// usage
// input channel: push / full; a transaction is taken when in_push is high and
//   in_full is low. cmd load writes one converted coefficient, cmd tick asks for
//   one byte of the 865-byte encoding. loads past the 653rd, ticks before all
//   coefficients or after the last byte are dropped with no result.
// result channel: empty / pop; out_out_byte, out_byte_index and out_last show the
//   oldest result while out_empty is low; out_last marks byte 864.
// a load is written into the store while the back end is idle. a tick that emits
//   the low byte of a fresh level operation goes through dispatch, read, multiply,
//   add and emit, after a dispatch, read, multiply and add for each preceding copy
//   step; further bytes of the same operation are emitted from the pending bytes.
//   the back end runs one transaction at a time through a single multiply-add.
// the front end and back end are parted by a two-entry queue; the result register
//   lets the next byte be prepared while the current one waits.
// when the receiver stalls the result holds, the back end waits and the queue
//   fills, after which in_full is raised.
// synchronous active-low reset clears all counters and flags; the store is not
//   cleared and needs no clearing pass.

module rounded_poly_mixed_radix_encoder_top #(
  parameter int COEFF_COUNT = rpmre_pkg::COEFF_COUNT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic                         in_cmd,
  input  logic [rpmre_pkg::COEF_W-1:0] in_coef,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [7:0]                   out_out_byte,
  output logic [rpmre_pkg::IDX_W-1:0]  out_byte_index,
  output logic                         out_last
);

  logic            q_push, q_full, q_pop, q_valid;
  rpmre_pkg::cmd_t q_in, q_head;

  assign in_full = q_full;

  rpmre_front #(.COEFF_COUNT(COEFF_COUNT)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_cmd  (in_cmd),
    .in_coef (in_coef),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_in)
  );

  rpmre_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  rpmre_back #(.COEFF_COUNT(COEFF_COUNT)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_out_byte   (out_out_byte),
    .out_byte_index (out_byte_index),
    .out_last       (out_last)
  );

endmodule

### bench/rounded_poly_mixed_radix_encoder_top_tb.sv
// testbench for the rounded polynomial mixed-radix encoder top level
// loads a full polynomial, drains the 865-byte encoding and checks every byte
// depends on rpmre_pkg and rounded_poly_mixed_radix_encoder_top
`timescale 1ns / 1ps

module rounded_poly_mixed_radix_encoder_top_tb;

  localparam int NCOEF  = 653;
  localparam int NBYTES = 865;

  typedef struct {
    logic [7:0]                  val;
    logic [rpmre_pkg::IDX_W-1:0] idx;
    logic                        lst;
  } enc_byte_t;

  typedef struct {
    logic                         cmd;
    logic [rpmre_pkg::COEF_W-1:0] coef;
  } stim_t;

  logic                         clk;
  logic                         rst_n;
  logic                         in_push;
  logic                         in_full;
  logic                         in_cmd;
  logic [rpmre_pkg::COEF_W-1:0] in_coef;
  logic                         out_empty;
  logic                         out_pop;
  logic [7:0]                   out_out_byte;
  logic [rpmre_pkg::IDX_W-1:0]  out_byte_index;
  logic                         out_last;

  rounded_poly_mixed_radix_encoder_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_cmd(in_cmd), .in_coef(in_coef),
    .out_empty(out_empty), .out_pop(out_pop), .out_out_byte(out_out_byte),
    .out_byte_index(out_byte_index), .out_last(out_last)
  );

  // shadow state of the encoder
  int unsigned       rounded_coef [NCOEF];
  longint unsigned   mix [NCOEF];
  logic [7:0]        encoding [NBYTES];
  int                wr_pos;
  int                coefs_loaded;
  int                bytes_drained;
  enc_byte_t         pending_bytes [$];
  int                errors;
  int                bytes_seen;
  bit                burst;

  // directed rows: ticks before loading, coefficient extremes, saturation
  stim_t directed [14] = '{
    '{rpmre_pkg::CMD_TICK, 13'd0}, '{rpmre_pkg::CMD_TICK, 13'd8191},
    '{rpmre_pkg::CMD_LOAD, 13'd0}, '{rpmre_pkg::CMD_LOAD, 13'd4620},
    '{rpmre_pkg::CMD_LOAD, 13'd2310}, '{rpmre_pkg::CMD_LOAD, 13'd2311},
    '{rpmre_pkg::CMD_LOAD, 13'd4621}, '{rpmre_pkg::CMD_LOAD, 13'd8191},
    '{rpmre_pkg::CMD_LOAD, 13'd1}, '{rpmre_pkg::CMD_LOAD, 13'd2312},
    '{rpmre_pkg::CMD_LOAD, 13'd4096}, '{rpmre_pkg::CMD_LOAD, 13'd2},
    '{rpmre_pkg::CMD_TICK, 13'd5555}, '{rpmre_pkg::CMD_LOAD, 13'd3}
  };

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // emit low bytes of a value into the encoding
  function automatic void put_le(longint unsigned v, int n);
    for (int k = 0; k < n; k++) begin
      if (wr_pos < NBYTES) encoding[wr_pos] = v[7:0];
      wr_pos++;
      v = v >> 8;
    end
  endfunction

  // one pairing level of the mixed-radix tree
  function automatic void merge_level(longint unsigned radix, int cnt, int nb);
    longint unsigned r;
    for (int i = 0; i < cnt; i++) begin
      r = mix[2*i] + mix[2*i+1] * radix;
      put_le(r, nb);
      mix[i] = r >> (8*nb);
    end
  endfunction

  // full encoding once the last coefficient is in, odd tails carried along
  function automatic void build_encoding();
    longint unsigned r;
    for (int i = 0; i < NCOEF; i++) mix[i] = rounded_coef[i];
    wr_pos = 0;
    merge_level(1541, 326, 1);
    mix[326] = mix[652];
    merge_level(9277, 163, 2);
    mix[163] = mix[326];
    merge_level(1314, 81, 1);
    r = mix[162] + mix[163] * 1314;
    put_le(r, 1);
    mix[81] = r >> 8;
    merge_level(6745, 40, 2);
    r = mix[80] + mix[81] * 6745;
    put_le(r, 2);
    mix[40] = r >> 16;
    merge_level(695, 20, 1);
    mix[20] = mix[40];
    merge_level(1887, 10, 1);
    mix[10] = mix[20];
    merge_level(13910, 5, 2);
    mix[5] = mix[10];
    r = mix[0] + mix[1] * 2953;
    put_le(r, 2);
    mix[0] = r >> 16;
    r = mix[2] + mix[3] * 2953;
    put_le(r, 2);
    mix[1] = r >> 16;
    r = mix[4] + mix[5] * 2953;
    put_le(r, 1);
    mix[2] = r >> 8;
    r = mix[0] + mix[1] * 134;
    put_le(r, 1);
    r = (r >> 8) + mix[2] * 71;
    put_le(r, 3);
  endfunction

  // model one accepted transaction
  function automatic void predict_encoder(logic cmd, logic [rpmre_pkg::COEF_W-1:0] coef);
    int unsigned c;
    int unsigned v;
    enc_byte_t   e;
    if (cmd == rpmre_pkg::CMD_LOAD) begin
      if (coefs_loaded >= NCOEF) return;
      c = (coef > 4620) ? 4620 : coef;
      v = (c >= 2311) ? c - 2311 : c + 2310;
      rounded_coef[coefs_loaded] = v / 3;
      coefs_loaded++;
      if (coefs_loaded == NCOEF) build_encoding();
    end else begin
      if (coefs_loaded < NCOEF || bytes_drained >= NBYTES) return;
      e.val = encoding[bytes_drained];
      e.idx = rpmre_pkg::IDX_W'(bytes_drained);
      e.lst = (bytes_drained == NBYTES-1);
      pending_bytes.push_back(e);
      bytes_drained++;
    end
  endfunction

  // input monitor
  always @(posedge clk) begin
    if (rst_n && in_push && !in_full) predict_encoder(in_cmd, in_coef);
  end

  // output checker
  always @(posedge clk) begin
    enc_byte_t e;
    if (rst_n && out_pop && !out_empty) begin
      bytes_seen++;
      if (pending_bytes.size() == 0) begin
        errors++;
        $display("%0t: unexpected byte %0d at index %0d", $time, out_out_byte,
                 out_byte_index);
      end else begin
        e = pending_bytes.pop_front();
        if (out_out_byte !== e.val || out_byte_index !== e.idx || out_last !== e.lst) begin
          errors++;
          $display("%0t: mismatch expected byte %0d idx %0d last %0b, got %0d idx %0d last %0b",
                   $time, e.val, e.idx, e.lst, out_out_byte, out_byte_index, out_last);
        end
      end
    end
  end

  // send one transaction, waiting for the queue to take it
  task automatic send_txn(logic cmd, logic [rpmre_pkg::COEF_W-1:0] coef);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_cmd  <= cmd;
    in_coef <= coef;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  function automatic logic [rpmre_pkg::COEF_W-1:0] rand_coef();
    if ($urandom_range(0, 19) == 0) return rpmre_pkg::COEF_W'($urandom_range(4621, 8191));
    return rpmre_pkg::COEF_W'($urandom_range(0, 4620));
  endfunction

  // result side stalls
  initial begin
    int gap;
    out_pop = 1'b0;
    @(posedge rst_n);
    forever begin
      gap = burst ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1'b1;
      @(posedge clk);
      while (out_empty) @(posedge clk);
    end
  end

  // main stimulus
  initial begin
    int loads_sent;
    int ticks_sent;
    int n;
    errors = 0; bytes_seen = 0; coefs_loaded = 0; bytes_drained = 0; burst = 0;
    rst_n = 1'b0; in_push = 1'b0; in_cmd = rpmre_pkg::CMD_LOAD; in_coef = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    loads_sent = 0;
    ticks_sent = 0;
    foreach (directed[i]) begin
      send_txn(directed[i].cmd, directed[i].coef);
      if (directed[i].cmd == rpmre_pkg::CMD_LOAD) loads_sent++;
    end
    // random coefficients with stray ticks that must be dropped
    n = 0;
    while (loads_sent < NCOEF) begin
      if (n % 150 == 0) burst = ($urandom_range(0, 2) == 0);
      n++;
      if ($urandom_range(0, 19) == 0) begin
        send_txn(rpmre_pkg::CMD_TICK, rpmre_pkg::COEF_W'($urandom_range(0, 8191)));
      end else begin
        send_txn(rpmre_pkg::CMD_LOAD, rand_coef());
        loads_sent++;
      end
    end
    // drain the encoding, stray loads dropped, a few ticks past the end
    while (ticks_sent < NBYTES + 6) begin
      if (n % 150 == 0) burst = ($urandom_range(0, 2) == 0);
      n++;
      if ($urandom_range(0, 19) == 0) begin
        send_txn(rpmre_pkg::CMD_LOAD, rand_coef());
      end else begin
        send_txn(rpmre_pkg::CMD_TICK, rpmre_pkg::COEF_W'($urandom_range(0, 8191)));
        ticks_sent++;
      end
    end
    in_push <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("loaded %0d coefficients, checked %0d encoded bytes", coefs_loaded, bytes_seen);
    $display("%0d transactions sent, %0d mismatches", n + 14, errors);
    if (errors == 0 && pending_bytes.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("timeout");
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
